[rtl/udpf_pkg.sv]
// ----------------------------------------------------------------------------
// udpf_pkg
// Shared types and constants for the data packet framer: packet byte codes,
// CRC-16 constants, sequencer states and CRC unit control.
// ----------------------------------------------------------------------------
package udpf_pkg;

    // Packet byte codes
    localparam logic [7:0] SYNC_BYTE = 8'h80;
    localparam logic [7:0] PID_DATA1 = 8'h4B;
    localparam logic [7:0] PID_DATA0 = 8'hC3;

    // CRC-16, reflected form
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Bit steps per byte in the serial CRC unit
    localparam int unsigned CRC_STEPS = 8;

    // Sequencer states, one-hot
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_CRC   = 7'b0000010,
        S_SYNC  = 7'b0000100,
        S_PID   = 7'b0001000,
        S_DATA  = 7'b0010000,
        S_CRCLO = 7'b0100000,
        S_CRCHI = 7'b1000000
    } state_t;

    // Control of the shared CRC unit
    typedef struct packed {
        logic init;   // restart the accumulator at CRC_INIT
        logic load;   // fold a new byte into the low bits
        logic step;   // one shift-and-reduce step
    } crc_ctrl_t;

endpackage

[rtl/usb_data_packet_framer_top.sv]
// ----------------------------------------------------------------------------
// usb_data_packet_framer_top
// Cuts a byte stream into data packets: sync, PID, payload, CRC-16.
// ----------------------------------------------------------------------------
// Input channel s_*: one payload byte per word on s_tdata, s_tlast on the
// final byte of a transfer. Output channel m_*: one packet byte per word,
// m_tlast on the CRC high byte of each packet, m_tuser on that byte when it
// also ends the transfer.
// Each accepted byte is written to the payload RAM and folded into the CRC
// by a bit-serial unit, one bit per cycle, so a byte holds the input until
// its eight CRC steps are done. When the packet is full (MAX_PAYLOAD
// bytes) or the byte carries s_tlast, the packet of N payload bytes is then
// sent as N + 4 words (sync, PID, N payload words, two CRC words) through
// the output register; the sequencer leaves S_CRC for S_SYNC after the
// last CRC step. s_tready is high only while the sequencer is idle.
// A stalled receiver holds the output register and the sequencer; nothing
// is dropped. After reset the block is idle, the CRC is 0xFFFF, the next
// packet is DATA1 and no payload is held.
// ----------------------------------------------------------------------------
module usb_data_packet_framer_top #(
    parameter int unsigned MAX_PAYLOAD = 8
) (
    input  logic       aclk,
    input  logic       aresetn,
    // Input channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] payload_byte
    input  logic       s_tlast,    // last_byte
    // Output channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] wire_byte
    output logic       m_tlast,    // packet_end
    output logic       m_tuser     // [0] transfer_end
);
    import udpf_pkg::*;

    localparam int unsigned FW = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [FW-1:0] FILL_MAX = FW'(MAX_PAYLOAD);

    state_t        state_reg, state_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic          last_reg, last_next;
    logic          data1_reg, data1_next;
    logic          in_xfer_reg, in_xfer_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_data_reg, out_data_next;
    logic          out_last_reg, out_last_next;
    logic          out_user_reg, out_user_next;

    logic          s_acc;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_rd_addr;
    logic [7:0]    ram_rd_data;
    crc_ctrl_t     crc_ctrl;
    logic [15:0]   crc_val;
    logic          crc_done;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign ram_we   = s_acc;

    // Read address follows the next index so data is ready when emitted
    assign ram_rd_addr = (idx_next < fill_reg) ? idx_next[AW-1:0] : '0;

    udpf_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (fill_reg[AW-1:0]),
        .wr_data (s_tdata),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    udpf_crc_unit u_crc (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (crc_ctrl),
        .data_in (s_tdata),
        .crc_out (crc_val),
        .done    (crc_done)
    );

    // Sequencer: accept, reduce CRC, then walk through the packet words
    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        data1_next     = data1_reg;
        in_xfer_next   = in_xfer_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        out_user_next  = out_user_reg;
        crc_ctrl       = '0;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    fill_next     = fill_reg + 1'b1;
                    last_next     = s_tlast;
                    crc_ctrl.load = 1'b1;
                    if (!in_xfer_reg) begin
                        in_xfer_next = 1'b1;
                        data1_next   = 1'b1;
                    end
                    state_next = S_CRC;
                end
            end
            S_CRC: begin
                crc_ctrl.step = 1'b1;
                if (crc_done) begin
                    if ((fill_reg == FILL_MAX) || last_reg) begin
                        idx_next   = '0;
                        state_next = S_SYNC;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_SYNC: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = SYNC_BYTE;
                    out_last_next  = 1'b0;
                    out_user_next  = 1'b0;
                    state_next     = S_PID;
                end
            end
            S_PID: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = data1_reg ? PID_DATA1 : PID_DATA0;
                    out_last_next  = 1'b0;
                    out_user_next  = 1'b0;
                    state_next     = S_DATA;
                end
            end
            S_DATA: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = ram_rd_data;
                    out_last_next  = 1'b0;
                    out_user_next  = 1'b0;
                    idx_next       = idx_reg + 1'b1;
                    if (idx_next == fill_reg) begin
                        state_next = S_CRCLO;
                    end
                end
            end
            S_CRCLO: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = ~crc_val[7:0];
                    out_last_next  = 1'b0;
                    out_user_next  = 1'b0;
                    state_next     = S_CRCHI;
                end
            end
            S_CRCHI: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_data_next  = ~crc_val[15:8];
                    out_last_next  = 1'b1;
                    out_user_next  = last_reg;
                    // Close the packet; toggle the PID, or restart at DATA1 when the transfer ends
                    crc_ctrl.init  = 1'b1;
                    fill_next      = '0;
                    if (last_reg) begin
                        data1_next   = 1'b1;
                        in_xfer_next = 1'b0;
                    end else begin
                        data1_next   = !data1_reg;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            data1_reg     <= 1'b1;
            in_xfer_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            data1_reg     <= data1_next;
            in_xfer_reg   <= in_xfer_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output word register
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

endmodule

[rtl/udpf_ram.sv]
// ----------------------------------------------------------------------------
// udpf_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module udpf_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 8,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/udpf_crc_unit.sv]
// ----------------------------------------------------------------------------
// udpf_crc_unit
// Bit-serial CRC-16 accumulator: a load folds a byte in, then eight shift
// steps reduce it by the reflected polynomial, one bit per cycle while step is set.
// ----------------------------------------------------------------------------
module udpf_crc_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  udpf_pkg::crc_ctrl_t ctrl,
    input  logic [7:0]          data_in,
    output logic [15:0]         crc_out,
    output logic                done
);
    import udpf_pkg::*;

    localparam int unsigned CW = $clog2(CRC_STEPS);

    logic [15:0]   crc_reg, crc_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Pick the accumulator update for this cycle
    always_comb begin
        crc_next = crc_reg;
        cnt_next = cnt_reg;
        if (ctrl.init) begin
            crc_next = CRC_INIT;
            cnt_next = '0;
        end else if (ctrl.load) begin
            crc_next = crc_reg ^ {8'h00, data_in};
            cnt_next = '0;
        end else if (ctrl.step) begin
            crc_next = crc_reg[0] ? ((crc_reg >> 1) ^ CRC_POLY) : (crc_reg >> 1);
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
            cnt_reg <= '0;
        end else begin
            crc_reg <= crc_next;
            cnt_reg <= cnt_next;
        end
    end

    assign crc_out = crc_reg;
    assign done    = ctrl.step && (cnt_reg == CW'(CRC_STEPS - 1));

endmodule

[rtl/udpf_checker.sv]
// ----------------------------------------------------------------------------
// udpf_checker
// Port-level checks of the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module udpf_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // Hold a stalled word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                                  && $stable(m_tuser))
        else $error("stalled output word changed");

    // Transfer end only on a packet end
    a_xfer_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("transfer end without packet end");

    // Input stays blocked while the CRC unit walks the byte
    a_crc_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready
                                 ##1 !s_tready ##1 !s_tready ##1 !s_tready ##1 !s_tready)
        else $error("input accepted during CRC steps");

    // No output word right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind usb_data_packet_framer_top udpf_checker u_udpf_checker (.*);

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for usb_data_packet_framer_top. Drives transfers of
// payload bytes into the input stream and predicts every packet byte (sync,
// PID, payload, CRC-16 low and high) with a local model of the framer. Each
// output word is compared with the oldest expected word. Runs a directed set
// first, then random transfers under several sender and receiver idle mixes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned MAX_PAYLOAD = 8;
    localparam int unsigned SETTLE_CYCLES = 120;
    localparam int unsigned RANDOM_BYTES_PER_PHASE = 43;

    // One expected output word
    typedef struct packed {
        logic [7:0] wire_byte;
        logic       packet_end;
        logic       transfer_end;
    } wire_word_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tlast = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       m_tuser;

    // Idle mix for the current phase, in percent
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;

    // Framer prediction state
    logic [7:0]  payload_buf [MAX_PAYLOAD];
    int unsigned payload_fill = 0;
    logic [15:0] crc_run = udpf_pkg::CRC_INIT;
    logic        next_data1 = 1'b1;
    logic        mid_transfer = 1'b0;
    wire_word_t  wire_expect_q [$];

    // Run statistics
    int unsigned error_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned transfers_sent = 0;
    int unsigned words_checked = 0;
    int unsigned packets_seen = 0;
    int unsigned transfers_seen = 0;

    usb_data_packet_framer_top #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Clock
    always #1 aclk = ~aclk;

    // Stall the receiver at random per the current mix
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // Fold one byte into the reflected CRC-16
    function automatic logic [15:0] crc16_fold(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ udpf_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic push_wire_word(input logic [7:0] b, input logic pend, input logic tend);
        wire_word_t w;
        w.wire_byte = b;
        w.packet_end = pend;
        w.transfer_end = tend;
        wire_expect_q.push_back(w);
    endtask

    // Advance the framer model by one accepted payload byte
    task automatic frame_payload_byte(input logic [7:0] b, input logic last);
        logic [15:0] crc_out;
        if (!mid_transfer) begin
            mid_transfer = 1'b1;
            next_data1 = 1'b1;
        end
        if (payload_fill < MAX_PAYLOAD) begin
            payload_buf[payload_fill] = b;
            payload_fill++;
            crc_run = crc16_fold(crc_run, b);
        end
        if (payload_fill == MAX_PAYLOAD || last) begin
            crc_out = ~crc_run;
            push_wire_word(udpf_pkg::SYNC_BYTE, 1'b0, 1'b0);
            push_wire_word(next_data1 ? udpf_pkg::PID_DATA1 : udpf_pkg::PID_DATA0, 1'b0, 1'b0);
            for (int i = 0; i < payload_fill; i++) begin
                push_wire_word(payload_buf[i], 1'b0, 1'b0);
            end
            push_wire_word(crc_out[7:0], 1'b0, 1'b0);
            push_wire_word(crc_out[15:8], 1'b1, last);
            payload_fill = 0;
            crc_run = udpf_pkg::CRC_INIT;
            next_data1 = ~next_data1;
            if (last) begin
                mid_transfer = 1'b0;
                next_data1 = 1'b1;
            end
        end
    endtask

    // Send one payload word, idling first at random; hold until accepted
    task automatic send_payload_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        frame_payload_byte(b, last);
        bytes_sent++;
        if (last) transfers_sent++;
    endtask

    // Send a transfer of random bytes
    task automatic send_random_transfer(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_payload_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // Drop the input valid, then hold until every expected word has been seen
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (wire_expect_q.size() != 0) @(posedge aclk);
    endtask

    // Check each output word against the oldest expectation
    always @(posedge aclk) begin
        wire_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            if (wire_expect_q.size() == 0) begin
                $error("unexpected word: wire_byte %02h packet_end %0b transfer_end %0b",
                       m_tdata, m_tlast, m_tuser);
                error_count++;
            end else begin
                w = wire_expect_q.pop_front();
                words_checked++;
                if (m_tdata !== w.wire_byte) begin
                    $error("wire_byte mismatch: expected %02h, got %02h", w.wire_byte, m_tdata);
                    error_count++;
                end
                if (m_tlast !== w.packet_end) begin
                    $error("packet_end mismatch: expected %0b, got %0b", w.packet_end, m_tlast);
                    error_count++;
                end
                if (m_tuser !== w.transfer_end) begin
                    $error("transfer_end mismatch: expected %0b, got %0b",
                           w.transfer_end, m_tuser);
                    error_count++;
                end
                if (w.packet_end) packets_seen++;
                if (w.transfer_end) transfers_seen++;
            end
        end
    end

    // Field extremes, short transfers, full packet on the last byte, PID toggle
    task automatic test_directed();
        logic [7:0] pattern [9];
        pattern = '{8'hFF, 8'h00, 8'h55, 8'hAA, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h3C};
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        // Single-byte transfers at both ends of the byte range
        send_payload_byte(8'h00, 1'b1);
        send_payload_byte(8'hFF, 1'b1);
        // Exactly one full packet that also ends the transfer: no empty packet
        for (int i = 0; i < 8; i++) begin
            send_payload_byte(pattern[i], i == 7);
        end
        // Full DATA1 packet, then a DATA0 packet with one byte
        for (int i = 0; i < 9; i++) begin
            send_payload_byte(pattern[8 - i], i == 8);
        end
        // Next transfer restarts at DATA1 after the toggle
        send_payload_byte(8'h12, 1'b0);
        send_payload_byte(8'hED, 1'b0);
        send_payload_byte(8'hC3, 1'b1);
        wait_drained();
    endtask

    // Random transfers: mostly short, some on packet multiples, some spanning two or three
    task automatic run_random_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned sent;
        int unsigned len;
        int unsigned pick;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        sent = 0;
        while (sent < RANDOM_BYTES_PER_PHASE) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) len = $urandom_range(1, 7);
            else if (pick < 80) len = MAX_PAYLOAD * $urandom_range(1, 2);
            else len = $urandom_range(9, 20);
            send_random_transfer(len);
            sent += len;
        end
        wait_drained();
    endtask

    task automatic test_random_no_idle();
        run_random_phase(0, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random_phase(50, 0);
    endtask

    task automatic test_random_receiver_stall();
        run_random_phase(0, 50);
    endtask

    task automatic test_random_both_idle();
        run_random_phase(14, 14);
    endtask

    // Reset, run every test, then settle and report
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random_no_idle();
        test_random_sender_idle();
        test_random_receiver_stall();
        test_random_both_idle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (wire_expect_q.size() != 0) begin
            $error("%0d expected words never arrived", wire_expect_q.size());
            error_count++;
        end
        $display("Covered %0d payload bytes in %0d transfers; checked %0d words,",
                 bytes_sent, transfers_sent, words_checked);
        $display("%0d packets and %0d transfer ends under four idle mixes.",
                 packets_seen, transfers_seen);
        if (error_count == 0) begin
            $display("usb_data_packet_framer_top verification clean");
        end else begin
            $display("usb_data_packet_framer_top verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2000000;
        $display("usb_data_packet_framer_top verification failed");
        $finish;
    end

endmodule
